@@ hdl/ics_pkg.sv @@
// Shared types and constants for the image column sums block.
`timescale 1ns / 1ps

package ics_pkg;

   // Field widths fixed by the interface.
   localparam int PIX_W   = 8;
   localparam int IDX_W   = 12;
   localparam int SUM_W   = 32;
   localparam int WIDTH_W = 13;

   // Default number of column accumulators.
   localparam int MAX_WIDTH_DEF = 4096;

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = WIDTH_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUM_MODE    = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH = 1'd1;
   localparam logic [WIDTH_W-1:0]    WIDTH_RESET     = 13'd4096;

   // Summing modes.
   localparam logic MODE_PLAIN  = 1'b0;
   localparam logic MODE_ABS_DX = 1'b1;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             first_row;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] column_index;
      logic [SUM_W-1:0] column_sum;
      logic             frame_done;
   } rsp_type;

   // Up to two results produced by one pixel, in delivery order.
   typedef struct packed {
      logic    emit0;
      logic    emit1;
      rsp_type item0;
      rsp_type item1;
   } push_type;

endpackage

@@ hdl/ics_rsp_queue.sv @@
// Four-entry queue; takes up to two results per cycle, delivers one unless stalled.
`timescale 1ns / 1ps

module ics_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  ics_pkg::push_type push,
   output logic              room_ok,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ics_pkg::rsp_type  rsp_data
);

   ics_pkg::rsp_type             q_ff [ics_pkg::QUEUE_DEPTH];
   logic [ics_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [ics_pkg::PTR_W-1:0]    tail_ff, tail_in;
   logic [ics_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ics_pkg::PTR_W-1:0]    slot1;
   logic [ics_pkg::CNT_W-1:0]    n_push;
   logic                         pop;

   // The producer may push two results only while at least two entries are free.
   assign room_ok   = count_ff <= ics_pkg::CNT_W'(ics_pkg::QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = q_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      n_push = '0;
      if (push_en) begin
         n_push = ics_pkg::CNT_W'(push.emit0) + ics_pkg::CNT_W'(push.emit1);
      end
      slot1    = push.emit0 ? tail_ff + ics_pkg::PTR_W'(1) : tail_ff;
      tail_in  = tail_ff + n_push[ics_pkg::PTR_W-1:0];
      head_in  = pop ? head_ff + ics_pkg::PTR_W'(1) : head_ff;
      count_in = count_ff + n_push - ics_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Result storage; the second result lands behind the first.
   always_ff @(posedge clock) begin
      if (push_en && push.emit0) begin
         q_ff[tail_ff] <= push.item0;
      end
      if (push_en && push.emit1) begin
         q_ff[slot1] <= push.item1;
      end
   end

endmodule

@@ hdl/image_column_sums.sv @@
// Top level: per-column sum accumulation over a synchronous memory.
// A result passes the update stage and the result queue before it is visible.
// Throughput: one pixel per cycle while the input is not stalled; the accumulator
// read-modify-write on the column memory (registered read, write on retire) with forwarding sets it.
// The input stalls only while three or more results wait in the queue.
// Reset clears control state and sets the configuration defaults; column sums stay
// undefined until a first-row pixel writes them, so there is no clearing pass.
`timescale 1ns / 1ps

module image_column_sums #(
   parameter int MAX_WIDTH = ics_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ics_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [ics_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ics_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ics_pkg::rsp_type               rsp_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > ics_pkg::WIDTH_W) ? CW + 1 : ics_pkg::WIDTH_W;
   localparam logic [LW-1:0] MAX_LW = LW'(MAX_WIDTH);

   // Configuration registers.
   logic                         mode_ff;
   logic [ics_pkg::WIDTH_W-1:0]  width_ff;

   // Row position and previous pixel.
   logic [CW-1:0]                counter_ff, counter_in;
   logic [ics_pkg::PIX_W-1:0]    prev_ff;

   // Update stage.
   logic                         s1_valid_ff;
   logic [CW-1:0]                s1_tgt_ff;
   logic [ics_pkg::PIX_W-1:0]    s1_val_ff;
   logic                         s1_upd_ff;
   logic                         s1_first_ff;
   logic                         s1_emit0_ff;
   logic                         s1_emit1_ff;
   logic                         s1_done0_ff;
   logic [ics_pkg::IDX_W-1:0]    s1_idx0_ff;
   logic [ics_pkg::IDX_W-1:0]    s1_idx1_ff;

   // Column memory and the last write, kept for forwarding.
   logic [ics_pkg::SUM_W-1:0]    mem [MAX_WIDTH];
   logic [ics_pkg::SUM_W-1:0]    rd_ff;
   logic                         lw_valid_ff;
   logic [CW-1:0]                lw_addr_ff;
   logic [ics_pkg::SUM_W-1:0]    lw_data_ff;

   logic                         accept;
   logic                         s1_fire;
   logic                         room_ok;
   logic [LW-1:0]                w_raw, w_eff, c_ext;
   logic [CW-1:0]                c_cur, tgt_in;
   logic [ics_pkg::PIX_W-1:0]    val_in, diff;
   logic                         last_col, upd_in;
   logic [CW+ics_pkg::IDX_W-1:0] idx_c_wide, idx_t_wide;
   logic [ics_pkg::SUM_W-1:0]    base_sum, new_sum;
   ics_pkg::push_type            push;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ics_pkg::MODE_PLAIN;
         width_ff <= ics_pkg::WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ics_pkg::CSR_SUM_MODE:    mode_ff  <= csr_wdata[0];
            ics_pkg::CSR_IMAGE_WIDTH: width_ff <= csr_wdata;
            default:                  ;
         endcase
      end
   end

   // The update stage moves on once the queue has room for two results.
   assign s1_fire   = s1_valid_ff && room_ok;
   assign req_stall = s1_valid_ff && !room_ok;
   assign accept    = req_valid && !req_stall;

   // Effective width and the column of the incoming pixel.
   always_comb begin
      w_raw = LW'(width_ff);
      if (w_raw == '0) begin
         w_eff = LW'(1);
      end else if (w_raw > MAX_LW) begin
         w_eff = MAX_LW;
      end else begin
         w_eff = w_raw;
      end
      c_cur      = (LW'(counter_ff) >= w_eff) ? '0 : counter_ff;
      c_ext      = LW'(c_cur);
      last_col   = c_ext == w_eff - LW'(1);
      counter_in = (c_ext + LW'(1) >= w_eff) ? '0 : CW'(c_ext + LW'(1));
   end

   // Target column and increment for each mode.
   always_comb begin
      diff = (req_data.pixel > prev_ff) ? req_data.pixel - prev_ff
                                        : prev_ff - req_data.pixel;
      if (mode_ff == ics_pkg::MODE_ABS_DX) begin
         tgt_in = c_cur - CW'(1);
         val_in = diff;
         upd_in = c_cur != '0;
      end else begin
         tgt_in = c_cur;
         val_in = req_data.pixel;
         upd_in = 1'b1;
      end
      idx_c_wide = {{ics_pkg::IDX_W{1'b0}}, c_cur};
      idx_t_wide = {{ics_pkg::IDX_W{1'b0}}, tgt_in};
   end

   // Row position, previous pixel and the update stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         prev_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            counter_ff <= counter_in;
            prev_ff    <= req_data.pixel;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tgt_ff   <= tgt_in;
         s1_val_ff   <= val_in;
         s1_upd_ff   <= upd_in;
         s1_first_ff <= req_data.first_row;
         s1_emit0_ff <= req_data.last_row && upd_in;
         s1_emit1_ff <= req_data.last_row && last_col &&
                        (mode_ff == ics_pkg::MODE_ABS_DX);
         s1_done0_ff <= last_col && (mode_ff == ics_pkg::MODE_PLAIN);
         s1_idx0_ff  <= idx_t_wide[ics_pkg::IDX_W-1:0];
         s1_idx1_ff  <= idx_c_wide[ics_pkg::IDX_W-1:0];
      end
   end

   // Column memory: read on accept, write when the update stage retires.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[tgt_in];
      end
      if (s1_fire && s1_upd_ff) begin
         mem[s1_tgt_ff] <= new_sum;
      end
   end

   // The last write is newer than any read of the same column.
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (s1_fire && s1_upd_ff) begin
         lw_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_upd_ff) begin
         lw_addr_ff <= s1_tgt_ff;
         lw_data_ff <= new_sum;
      end
   end

   // Accumulate, or overwrite on the first row.
   always_comb begin
      base_sum = (lw_valid_ff && lw_addr_ff == s1_tgt_ff) ? lw_data_ff : rd_ff;
      if (s1_first_ff) begin
         new_sum = ics_pkg::SUM_W'(s1_val_ff);
      end else begin
         new_sum = base_sum + ics_pkg::SUM_W'(s1_val_ff);
      end
   end

   // Results of the retiring pixel.
   always_comb begin
      push.emit0              = s1_emit0_ff;
      push.emit1              = s1_emit1_ff;
      push.item0.column_index = s1_idx0_ff;
      push.item0.column_sum   = new_sum;
      push.item0.frame_done   = s1_done0_ff;
      push.item1.column_index = s1_idx1_ff;
      push.item1.column_sum   = '0;
      push.item1.frame_done   = 1'b1;
   end

   ics_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (s1_fire),
      .push      (push),
      .room_ok   (room_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/ics_checker.sv @@
// Port-level checks for the image column sums block, bound to the top level.
`timescale 1ns / 1ps

module ics_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ics_pkg::rsp_type rsp_data
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // With no result waiting, the block always takes a request.
   assert property (@(posedge clock) !rsp_valid |-> !req_stall)
      else $error("request stalled while the result side is empty");

   // A first result follows a request that was accepted and passed the update stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without a request");

endmodule

bind image_column_sums ics_checker u_ics_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
